// ===== rtl/core/video_register_file_line_timer_macros.svh =====
// assertion macros for the video register file
`ifndef VIDEO_REGISTER_FILE_LINE_TIMER_MACROS_SVH
`define VIDEO_REGISTER_FILE_LINE_TIMER_MACROS_SVH

// implication checked every clock outside reset
`define VRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define VRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/vrf_pkg.sv =====
// ----------------------------------------------------------------------------
// vrf_pkg
// types, constants and address map of the video register file
// ----------------------------------------------------------------------------
package vrf_pkg;

    localparam int LINES_PER_FRAME_DEF = 262;
    localparam int VISIBLE_LINES_DEF   = 240;
    localparam int SPRITE_WORDS_DEF    = 1024;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_DMA   = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] addr;
        logic [15:0] data;
    } t_request;

    typedef struct packed {
        logic [15:0] read_data;
        logic [15:0] irq_flags_out;
        logic        frame_done;
        logic        dma_active;
        logic [14:0] dma_fetch_addr;
        logic        unknown_access;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP,
        ST_CLEAR
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic respond;
        logic clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
    } t_status;

    localparam logic [15:0] ADDR_LAYER_LO  = 16'h2810;
    localparam logic [15:0] ADDR_LAYER_HI  = 16'h281b;
    localparam logic [15:0] ADDR_VSCALE    = 16'h281c;
    localparam logic [15:0] ADDR_VMOVE     = 16'h281d;
    localparam logic [15:0] ADDR_SEG0      = 16'h2820;
    localparam logic [15:0] ADDR_SEG1      = 16'h2821;
    localparam logic [15:0] ADDR_SPRSEG    = 16'h2822;
    localparam logic [15:0] ADDR_BLEND     = 16'h282a;
    localparam logic [15:0] ADDR_FADE      = 16'h2830;
    localparam logic [15:0] ADDR_LINECMP   = 16'h2836;
    localparam logic [15:0] ADDR_COLCMP    = 16'h2837;
    localparam logic [15:0] ADDR_CURLINE   = 16'h2838;
    localparam logic [15:0] ADDR_HUE       = 16'h283c;
    localparam logic [15:0] ADDR_INTERLACE = 16'h283d;
    localparam logic [15:0] ADDR_PENX      = 16'h283e;
    localparam logic [15:0] ADDR_PENY      = 16'h283f;
    localparam logic [15:0] ADDR_SPREN     = 16'h2842;
    localparam logic [15:0] ADDR_LCD       = 16'h2854;
    localparam logic [15:0] ADDR_IRQEN     = 16'h2862;
    localparam logic [15:0] ADDR_IRQFLAG   = 16'h2863;
    localparam logic [15:0] ADDR_DMASRC    = 16'h2870;
    localparam logic [15:0] ADDR_DMADST    = 16'h2871;
    localparam logic [15:0] ADDR_DMASIZE   = 16'h2872;

    localparam logic [5:0] WIN_SCROLL  = 6'h29;
    localparam logic [5:0] WIN_SCALE   = 6'h2a;
    localparam logic [5:0] WIN_PALETTE = 6'h2b;
    localparam logic [3:0] WIN_SPRITE  = 4'hb;

    localparam logic [15:0] IRQ_VBLANK = 16'h0001;
    localparam logic [15:0] IRQ_LINE   = 16'h0002;
    localparam logic [15:0] IRQ_DMA    = 16'h0004;

    localparam logic [10:0] DMA_FULL = 11'h400;

endpackage

// ===== rtl/core/vrf_ram.sv =====
// ----------------------------------------------------------------------------
// vrf_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module vrf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== rtl/core/vrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// vrf_ctrl
// sequencer: clearing pass after reset, then execute and respond per request
// ----------------------------------------------------------------------------
module vrf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  vrf_pkg::t_status i_status,
    output vrf_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    vrf_pkg::t_state r_state;
    vrf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vrf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vrf_pkg::ST_CLEAR: if (i_status.clear_done) n_state = vrf_pkg::ST_IDLE;
            vrf_pkg::ST_IDLE:  if (i_start) n_state = vrf_pkg::ST_EXEC;
            vrf_pkg::ST_EXEC:  n_state = vrf_pkg::ST_RESP;
            vrf_pkg::ST_RESP:  n_state = vrf_pkg::ST_IDLE;
            default:           n_state = vrf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            vrf_pkg::ST_CLEAR: o_cmd.clear = 1'b1;
            vrf_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.exec = i_start;
            end
            vrf_pkg::ST_EXEC:  ;
            vrf_pkg::ST_RESP:  o_cmd.respond = 1'b1;
            default:           ;
        endcase
    end

endmodule

// ===== rtl/core/vrf_datapath.sv =====
// ----------------------------------------------------------------------------
// vrf_datapath
// register file, window memories, line counter and sprite dma
// ----------------------------------------------------------------------------
module vrf_datapath #(
    parameter int LINES_PER_FRAME = vrf_pkg::LINES_PER_FRAME_DEF,
    parameter int VISIBLE_LINES   = vrf_pkg::VISIBLE_LINES_DEF,
    parameter int SPRITE_WORDS    = vrf_pkg::SPRITE_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vrf_pkg::t_cmd     i_cmd,
    input  vrf_pkg::t_request i_req,
    output vrf_pkg::t_status  o_status,
    output vrf_pkg::t_result  o_result,
    output logic              o_valid
);

    localparam int SAW = $clog2(SPRITE_WORDS);
    localparam logic [8:0] LAST_LINE = 9'(LINES_PER_FRAME - 1);
    localparam logic [8:0] VIS_LINE  = 9'(VISIBLE_LINES);
    localparam logic [9:0] LAST_CLR  = 10'(SPRITE_WORDS - 1);

    // scalar registers
    logic [8:0]  r_scroll_x [2];
    logic [7:0]  r_scroll_y [2];
    logic [15:0] r_attr [2];
    logic [15:0] r_ctrl [2];
    logic [15:0] r_map [2];
    logic [15:0] r_abase [2];
    logic [7:0]  r_vscale;
    logic [8:0]  r_vmove;
    logic [15:0] r_seg [2];
    logic [15:0] r_sprseg;
    logic [1:0]  r_blend;
    logic [7:0]  r_fade;
    logic [8:0]  r_linecmp;
    logic [8:0]  r_colcmp;
    logic [8:0]  r_line;
    logic [7:0]  r_hue;
    logic [2:0]  r_interlace;
    logic [8:0]  r_penx;
    logic [8:0]  r_peny;
    logic        r_spren;
    logic [5:0]  r_lcd;
    logic [15:0] r_irqen;
    logic [15:0] r_irq;
    logic [13:0] r_dsrc;
    logic [9:0]  r_ddst;
    logic [10:0] r_drem;
    logic [9:0]  r_didx;

    logic [9:0]  r_clr;
    vrf_pkg::t_request r_req;
    logic [15:0] r_sdata;
    logic        r_unk;
    logic        r_fdone;
    logic [1:0]  r_win;
    logic        r_winrd;
    vrf_pkg::t_result r_res;
    logic        r_valid;

    // decode of the incoming request
    logic [15:0] a;
    logic [15:0] d;
    logic        below;
    logic        is_layer;
    logic [3:0]  k;
    logic        lyr;
    logic [2:0]  kk;
    logic        smap;
    logic [15:0] sval;
    logic        win_hit;
    logic [1:0]  win_sel;
    logic [9:0]  win_off;

    always_comb begin
        a        = i_req.addr;
        d        = i_req.data;
        below    = a < 16'h2900;
        is_layer = a >= vrf_pkg::ADDR_LAYER_LO && a <= vrf_pkg::ADDR_LAYER_HI;
        k        = a[3:0];
        lyr      = k >= 4'd6;
        kk       = lyr ? 3'(k - 4'd6) : k[2:0];
        smap     = 1'b1;
        sval     = '0;
        if (is_layer) begin
            unique case (kk)
                3'd0:    sval = {7'd0, r_scroll_x[lyr]};
                3'd1:    sval = {8'd0, r_scroll_y[lyr]};
                3'd2:    sval = r_attr[lyr];
                3'd3:    sval = r_ctrl[lyr];
                3'd4:    sval = r_map[lyr];
                default: sval = r_abase[lyr];
            endcase
        end else begin
            unique case (a)
                vrf_pkg::ADDR_VSCALE:    sval = {8'd0, r_vscale};
                vrf_pkg::ADDR_VMOVE:     sval = {7'd0, r_vmove};
                vrf_pkg::ADDR_SEG0:      sval = r_seg[0];
                vrf_pkg::ADDR_SEG1:      sval = r_seg[1];
                vrf_pkg::ADDR_SPRSEG:    sval = r_sprseg;
                vrf_pkg::ADDR_BLEND:     sval = {14'd0, r_blend};
                vrf_pkg::ADDR_FADE:      sval = {8'd0, r_fade};
                vrf_pkg::ADDR_LINECMP:   sval = {7'd0, r_linecmp};
                vrf_pkg::ADDR_COLCMP:    sval = {7'd0, r_colcmp};
                vrf_pkg::ADDR_CURLINE:   sval = {7'd0, r_line};
                vrf_pkg::ADDR_HUE:       sval = {8'd0, r_hue};
                vrf_pkg::ADDR_INTERLACE: sval = {13'd0, r_interlace};
                vrf_pkg::ADDR_PENX:      sval = {7'd0, r_penx};
                vrf_pkg::ADDR_PENY:      sval = {7'd0, r_peny};
                vrf_pkg::ADDR_SPREN:     sval = {15'd0, r_spren};
                vrf_pkg::ADDR_LCD:       sval = {10'd0, r_lcd};
                vrf_pkg::ADDR_IRQEN:     sval = r_irqen;
                vrf_pkg::ADDR_IRQFLAG:   sval = r_irq;
                vrf_pkg::ADDR_DMASRC:    sval = {2'd0, r_dsrc};
                vrf_pkg::ADDR_DMADST:    sval = {6'd0, r_ddst};
                vrf_pkg::ADDR_DMASIZE:   sval = {5'd0, r_drem};
                default:                 smap = 1'b0;
            endcase
        end
        win_sel = 2'd0;
        win_hit = 1'b0;
        win_off = {2'd0, a[7:0]};
        if (a[15:8] == {2'd0, vrf_pkg::WIN_SCROLL}) begin
            win_hit = 1'b1;
            win_sel = 2'd0;
        end else if (a[15:8] == {2'd0, vrf_pkg::WIN_SCALE}) begin
            win_hit = 1'b1;
            win_sel = 2'd1;
        end else if (a[15:8] == {2'd0, vrf_pkg::WIN_PALETTE}) begin
            win_hit = 1'b1;
            win_sel = 2'd2;
        end else if (a[15:10] == {2'd0, vrf_pkg::WIN_SPRITE}) begin
            win_off = a[9:0];
            win_hit = {1'b0, a[9:0]} < 11'(SPRITE_WORDS);
            win_sel = 2'd3;
        end
    end

    // dma step
    logic        dma_go;
    logic [9:0]  dma_dst;

    always_comb begin
        dma_go  = i_cmd.exec && i_req.func == vrf_pkg::FUNC_DMA && r_drem != '0;
        dma_dst = r_ddst + r_didx;
    end

    // memory ports
    logic        we [4];
    logic [9:0]  maddr [4];
    logic [15:0] wdat [4];
    logic [15:0] rdat [4];
    logic        bus_wr;

    always_comb begin
        bus_wr = i_cmd.exec && i_req.func == vrf_pkg::FUNC_WRITE && !below && win_hit;
        for (int i = 0; i < 4; i++) begin
            we[i]    = i_cmd.clear || (bus_wr && win_sel == 2'(i));
            // captured address keeps the read data steady until the response
            maddr[i] = i_cmd.clear ? r_clr : (i_cmd.exec ? win_off : r_req.addr[9:0]);
            wdat[i]  = i_cmd.clear ? 16'd0 : d;
        end
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.clear && r_clr[9:8] != 2'd0) begin
                we[i] = 1'b0;
            end
        end
        if (dma_go) begin
            we[3]    = {1'b0, dma_dst} < 11'(SPRITE_WORDS);
            maddr[3] = dma_dst;
            wdat[3]  = d;
        end
    end

    vrf_ram #(.WIDTH(16), .DEPTH(256)) u_scroll (
        .i_clk(i_clk), .i_we(we[0]), .i_addr(maddr[0][7:0]),
        .i_wdata(wdat[0]), .o_rdata(rdat[0]));
    vrf_ram #(.WIDTH(16), .DEPTH(256)) u_scale (
        .i_clk(i_clk), .i_we(we[1]), .i_addr(maddr[1][7:0]),
        .i_wdata(wdat[1]), .o_rdata(rdat[1]));
    vrf_ram #(.WIDTH(16), .DEPTH(256)) u_palette (
        .i_clk(i_clk), .i_we(we[2]), .i_addr(maddr[2][7:0]),
        .i_wdata(wdat[2]), .o_rdata(rdat[2]));
    vrf_ram #(.WIDTH(16), .DEPTH(SPRITE_WORDS)) u_sprite (
        .i_clk(i_clk), .i_we(we[3]), .i_addr(maddr[3][SAW-1:0]),
        .i_wdata(wdat[3]), .o_rdata(rdat[3]));

    assign o_status.clear_done = i_cmd.clear && r_clr == LAST_CLR;

    // clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + 10'd1;
        end
    end

    // scalar state update
    logic wr;
    logic tick;
    logic [15:0] n_irq;

    always_comb begin
        wr    = i_cmd.exec && i_req.func == vrf_pkg::FUNC_WRITE && below;
        tick  = i_cmd.exec && i_req.func == vrf_pkg::FUNC_TICK;
        n_irq = r_irq;
        if (wr && a == vrf_pkg::ADDR_IRQFLAG) begin
            n_irq = r_irq & ~d;
        end
        if (tick && r_line == r_linecmp) begin
            n_irq = n_irq | vrf_pkg::IRQ_LINE;
        end
        if (tick && r_line == VIS_LINE) begin
            n_irq = n_irq | vrf_pkg::IRQ_VBLANK;
        end
        if (dma_go && r_drem == 11'd1) begin
            n_irq = n_irq | vrf_pkg::IRQ_DMA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_scroll_x[i] <= '0;
                r_scroll_y[i] <= '0;
                r_attr[i]     <= '0;
                r_ctrl[i]     <= '0;
                r_map[i]      <= '0;
                r_abase[i]    <= '0;
                r_seg[i]      <= '0;
            end
            r_vscale    <= '0;
            r_vmove     <= '0;
            r_sprseg    <= '0;
            r_blend     <= '0;
            r_fade      <= '0;
            r_linecmp   <= '0;
            r_colcmp    <= '0;
            r_line      <= '0;
            r_hue       <= '0;
            r_interlace <= '0;
            r_penx      <= '0;
            r_peny      <= '0;
            r_spren     <= '0;
            r_lcd       <= '0;
            r_irqen     <= '1;
            r_irq       <= '1;
            r_dsrc      <= '0;
            r_ddst      <= '0;
            r_drem      <= '0;
            r_didx      <= '0;
        end else begin
            r_irq <= n_irq;
            if (wr && is_layer) begin
                unique case (kk)
                    3'd0:    r_scroll_x[lyr] <= d[8:0];
                    3'd1:    r_scroll_y[lyr] <= d[7:0];
                    3'd2:    r_attr[lyr]     <= d;
                    3'd3:    r_ctrl[lyr]     <= d;
                    3'd4:    r_map[lyr]      <= d;
                    default: r_abase[lyr]    <= d;
                endcase
            end else if (wr) begin
                unique case (a)
                    vrf_pkg::ADDR_VSCALE:    r_vscale    <= d[7:0];
                    vrf_pkg::ADDR_VMOVE:     r_vmove     <= d[8:0];
                    vrf_pkg::ADDR_SEG0:      r_seg[0]    <= d;
                    vrf_pkg::ADDR_SEG1:      r_seg[1]    <= d;
                    vrf_pkg::ADDR_SPRSEG:    r_sprseg    <= d;
                    vrf_pkg::ADDR_BLEND:     r_blend     <= d[1:0];
                    vrf_pkg::ADDR_FADE:      r_fade      <= d[7:0];
                    vrf_pkg::ADDR_LINECMP:   r_linecmp   <= d[8:0];
                    vrf_pkg::ADDR_COLCMP:    r_colcmp    <= d[8:0];
                    vrf_pkg::ADDR_HUE:       r_hue       <= d[7:0];
                    vrf_pkg::ADDR_INTERLACE: r_interlace <= d[2:0] & 3'b101;
                    vrf_pkg::ADDR_PENX:      r_penx      <= d[8:0];
                    vrf_pkg::ADDR_PENY:      r_peny      <= d[8:0];
                    vrf_pkg::ADDR_SPREN:     r_spren     <= d[0];
                    vrf_pkg::ADDR_LCD:       r_lcd       <= d[5:0];
                    vrf_pkg::ADDR_IRQEN:     r_irqen     <= d;
                    vrf_pkg::ADDR_DMASRC:    r_dsrc      <= d[13:0];
                    vrf_pkg::ADDR_DMADST:    r_ddst      <= d[9:0];
                    vrf_pkg::ADDR_DMASIZE: begin
                        r_drem <= (d[9:0] == '0) ? vrf_pkg::DMA_FULL : {1'b0, d[9:0]};
                        r_didx <= '0;
                    end
                    default: ;
                endcase
            end
            if (tick) begin
                r_line <= (r_line >= LAST_LINE) ? 9'd0 : r_line + 9'd1;
            end
            if (dma_go) begin
                r_didx <= r_didx + 10'd1;
                r_drem <= r_drem - 11'd1;
            end
        end
    end

    // capture of per request information for the response cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_req   <= i_req;
            r_sdata <= sval;
            r_win   <= win_sel;
            r_winrd <= !below && win_hit;
            r_fdone <= i_req.func == vrf_pkg::FUNC_TICK && r_line >= LAST_LINE;
            r_unk   <= (i_req.func == vrf_pkg::FUNC_READ &&
                        (below ? !smap : !win_hit)) ||
                       (i_req.func == vrf_pkg::FUNC_WRITE &&
                        (below ? (!smap || a == vrf_pkg::ADDR_CURLINE) : !win_hit));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            r_res.read_data <= '0;
            if (r_req.func == vrf_pkg::FUNC_READ && !r_unk) begin
                r_res.read_data <= r_winrd ? rdat[r_win] : r_sdata;
            end
            r_res.irq_flags_out  <= r_irq;
            r_res.frame_done     <= r_fdone;
            r_res.dma_active     <= r_drem != '0;
            r_res.dma_fetch_addr <= (r_drem != '0) ? 15'({1'b0, r_dsrc} + {5'd0, r_didx})
                                                   : 15'd0;
            r_res.unknown_access <= r_unk;
        end
    end

    assign o_result = r_res;
    assign o_valid  = r_valid;

endmodule

// ===== rtl/core/video_register_file_line_timer.sv =====
// ----------------------------------------------------------------------------
// video_register_file_line_timer
// register side of a tile/sprite video unit
// ----------------------------------------------------------------------------
// From start to result strobe: the start cycle decodes and updates state, the
// exec state does the registered read of the window memories, the respond
// state forms the result and the strobe presents it; busy is high in exec and
// respond, and a new request may start in the cycle the strobe shows. After
// reset the block clears its four window memories, one word of each per cycle
// while words remain, busy until all are clear. The result cannot be stalled.
module video_register_file_line_timer #(
    parameter int LINES_PER_FRAME = vrf_pkg::LINES_PER_FRAME_DEF,
    parameter int VISIBLE_LINES   = vrf_pkg::VISIBLE_LINES_DEF,
    parameter int SPRITE_WORDS    = vrf_pkg::SPRITE_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  vrf_pkg::t_request i_request,
    output logic              busy,
    output logic              o_strobe,
    output vrf_pkg::t_result  o_result
);

`include "video_register_file_line_timer_macros.svh"

    vrf_pkg::t_cmd    cmd;
    vrf_pkg::t_status status;

    vrf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_status(status), .o_cmd(cmd), .o_busy(busy));

    vrf_datapath #(
        .LINES_PER_FRAME(LINES_PER_FRAME),
        .VISIBLE_LINES(VISIBLE_LINES),
        .SPRITE_WORDS(SPRITE_WORDS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req(i_request),
        .o_status(status), .o_result(o_result), .o_valid(o_strobe));

    `VRF_ASSERT_NEXT(a_exec_busy, i_clk, i_rst_n, cmd.exec, busy && !o_strobe)
    `VRF_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(cmd))
    `VRF_ASSERT_NEXT(a_resp_strobe, i_clk, i_rst_n, cmd.respond, o_strobe)

endmodule
